[src/sdv_pkg.sv]
`timescale 1ns / 1ps

package sdv_pkg;

  // Block geometry.
  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned NUM_WORDS  = 8;
  localparam int unsigned SCHED_LEN  = 16;
  localparam int unsigned QDEPTH     = 2;

  // Padding constants.
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;

  // One block on its way from the packer to the compression engine.
  typedef struct packed {
    logic [BLOCK_BITS-1:0] block;
    logic                  last_blk;
  } blk_job_t;

  localparam logic [31:0] INIT_HASH [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
  endfunction

endpackage

[src/sdv_front.sv]
`timescale 1ns / 1ps

module sdv_front import sdv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       q_full,
  output logic       push,
  output blk_job_t   push_job
);

  typedef enum logic {F_DATA, F_PAD} front_state_t;

  front_state_t           state;
  logic [5:0]             fill;
  logic                   mark_pending;
  logic                   wrap;
  logic [63:0]            bit_length;
  logic [BLOCK_BITS-1:0]  block_sr;

  logic       have_byte;
  logic [7:0] byte_val;
  logic       len_phase;
  logic       at_end;
  logic       wr_byte;

  // The length bytes go in once the mark is placed and no extra block is due.
  assign len_phase = (state == F_PAD) && !mark_pending && !wrap && (fill >= LEN_START);
  assign at_end    = (fill == LAST_POS);
  assign have_byte = (state == F_DATA) ? in_valid : 1'b1;

  // Select the byte that enters the block: message data, the pad mark,
  // the length field or zero fill.
  always_comb begin
    if (state == F_DATA) begin
      byte_val = data_byte;
    end else if (mark_pending) begin
      byte_val = PAD_MARK;
    end else if (len_phase) begin
      byte_val = bit_length[63:56];
    end else begin
      byte_val = 8'h00;
    end
  end

  // A byte that closes a block waits for room in the queue.
  assign wr_byte  = have_byte && (!at_end || !q_full);
  assign in_ready = (state == F_DATA) && (!at_end || !q_full);
  assign push     = wr_byte && at_end;

  assign push_job.block    = {block_sr[BLOCK_BITS-9:0], byte_val};
  assign push_job.last_blk = len_phase;

  // Byte packing and padding sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_DATA;
      fill         <= '0;
      mark_pending <= 1'b0;
      wrap         <= 1'b0;
      bit_length   <= '0;
    end else if (wr_byte) begin
      fill <= fill + 6'd1;
      unique case (state)
        F_DATA: begin
          bit_length <= bit_length + 64'd8;
          if (final_byte) begin
            state        <= F_PAD;
            mark_pending <= 1'b1;
          end
        end
        F_PAD: begin
          // A mark in the last slot closes its block itself, so the length
          // goes straight into the next block.
          if (mark_pending) begin
            mark_pending <= 1'b0;
            wrap         <= (fill >= LEN_START) && !at_end;
          end else if (wrap && at_end) begin
            wrap <= 1'b0;
          end
          // Shifting the length out leaves it zero for the next message.
          if (len_phase) begin
            bit_length <= {bit_length[55:0], 8'h00};
            if (at_end) begin
              state <= F_DATA;
            end
          end
        end
        default: state <= F_DATA;
      endcase
    end
  end

  // Block shift line; the first byte of the block ends up on top.
  always_ff @(posedge clk) begin
    if (wr_byte) begin
      block_sr <= {block_sr[BLOCK_BITS-9:0], byte_val};
    end
  end

endmodule

[src/sdv_block_fifo.sv]
`timescale 1ns / 1ps

module sdv_block_fifo import sdv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  blk_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output blk_job_t head_job
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  blk_job_t           mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head_job  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/sdv_back.sv]
`timescale 1ns / 1ps

module sdv_back import sdv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  input  blk_job_t     job,
  output logic         pop,
  input  logic [255:0] expected,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  digest_word,
  output logic [2:0]   word_number,
  output logic         last_word,
  output logic         digest_matches
);

  typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_OUT} back_state_t;

  back_state_t  state;
  logic [31:0]  hash [NUM_WORDS];
  logic [31:0]  r [NUM_WORDS];
  logic [31:0]  wr [SCHED_LEN];
  logic [5:0]   round;
  logic         last_job;
  logic [2:0]   word_idx;

  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  w_new;
  logic         hash_match;
  logic         load_out;

  assign pop = (state == B_IDLE) && job_valid;

  // One compression round and one schedule word.
  always_comb begin
    t1 = r[7] + big_sigma1(r[4]) + ((r[4] & r[5]) ^ (~r[4] & r[6]))
         + ROUND_K[round] + wr[0];
    t2 = big_sigma0(r[0]) + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
    w_new = small_sigma1(wr[14]) + wr[9] + small_sigma0(wr[1]) + wr[0];
  end

  // Full digest compare against the expected registers.
  assign hash_match = ({hash[0], hash[1], hash[2], hash[3],
                        hash[4], hash[5], hash[6], hash[7]} == expected);

  assign load_out = (state == B_OUT) && (!out_valid || out_ready);

  // Compression sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      round     <= '0;
      word_idx  <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        hash[i] <= INIT_HASH[i];
      end
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < SCHED_LEN; i++) begin
              wr[i] <= job.block[BLOCK_BITS-1-32*i -: 32];
            end
            for (int i = 0; i < NUM_WORDS; i++) begin
              r[i] <= hash[i];
            end
            last_job <= job.last_blk;
            round    <= '0;
            state    <= B_ROUND;
          end
        end
        B_ROUND: begin
          r[0] <= t1 + t2;
          r[1] <= r[0];
          r[2] <= r[1];
          r[3] <= r[2];
          r[4] <= r[3] + t1;
          r[5] <= r[4];
          r[6] <= r[5];
          r[7] <= r[6];
          for (int i = 0; i < SCHED_LEN - 1; i++) begin
            wr[i] <= wr[i+1];
          end
          wr[SCHED_LEN-1] <= w_new;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= B_ADD;
          end
        end
        B_ADD: begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            hash[i] <= hash[i] + r[i];
          end
          word_idx <= '0;
          state    <= last_job ? B_OUT : B_IDLE;
        end
        B_OUT: begin
          if (load_out) begin
            out_valid      <= 1'b1;
            digest_word    <= hash[word_idx];
            word_number    <= word_idx;
            last_word      <= (word_idx == 3'd7);
            digest_matches <= (word_idx == 3'd7) && hash_match;
            word_idx       <= word_idx + 3'd1;
            // The last word is out; start the next message from the initial hash.
            if (word_idx == 3'd7) begin
              for (int i = 0; i < NUM_WORDS; i++) begin
                hash[i] <= INIT_HASH[i];
              end
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[src/sha256_digest_verify_unit.sv]
`timescale 1ns / 1ps
// SHA-256 streaming hasher with digest check.
// Input channel (in_valid/in_ready): one message byte per request, with
// final_byte set on the last byte of the message. A packer builds 64-byte
// blocks and hands them through a two-entry block queue to a compression
// engine that runs one round per cycle.
// Throughput: one byte per cycle while the queue has room; a block passes
// through the engine as one load, 64 rounds and one hash add, so for long
// messages the round loop sets the sustained rate.
// Closing a message: the packer writes the pad mark, zero fill and the
// 64-bit length one byte per cycle while the queue has room, with input
// held off, then the engine compresses the one or two closing blocks.
// Output channel (out_valid/out_ready): eight digest words, word 0 first,
// one per cycle through an output register; word 7 carries last_word and
// digest_matches. A stalled receiver holds the word in place and the engine
// waits; the packer keeps taking bytes until the queue fills.
// Configuration channel: cfg_index 0 to 3 selects an expected-digest
// register, other indexes are ignored; write only while the block is idle.
// Reset loads the initial hash values and empties the queue; no clearing
// pass is needed.

module sha256_digest_verify_unit import sdv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word,
  output logic        digest_matches,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [7:0] REG_EXP0 = 8'd0;
  localparam logic [7:0] REG_EXP1 = 8'd1;
  localparam logic [7:0] REG_EXP2 = 8'd2;
  localparam logic [7:0] REG_EXP3 = 8'd3;

  logic [63:0] expected_digest_0;
  logic [63:0] expected_digest_1;
  logic [63:0] expected_digest_2;
  logic [63:0] expected_digest_3;

  logic     push;
  blk_job_t push_job;
  logic     q_full;
  logic     pop;
  logic     q_not_empty;
  blk_job_t head_job;

  assign cfg_ready = 1'b1;

  // Expected digest registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_digest_0 <= '0;
      expected_digest_1 <= '0;
      expected_digest_2 <= '0;
      expected_digest_3 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXP0: expected_digest_0 <= cfg_data;
        REG_EXP1: expected_digest_1 <= cfg_data;
        REG_EXP2: expected_digest_2 <= cfg_data;
        REG_EXP3: expected_digest_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  sdv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  sdv_block_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  sdv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_not_empty),
    .job            (head_job),
    .pop            (pop),
    .expected       ({expected_digest_0, expected_digest_1,
                      expected_digest_2, expected_digest_3}),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .last_word      (last_word),
    .digest_matches (digest_matches)
  );

  // The packer never pushes a block into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("block pushed into a full queue");

  // The engine only takes a block that is in the queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> q_not_empty)
    else $error("block popped from an empty queue");

  // A match is only reported with the final digest word.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && digest_matches) |-> (last_word && word_number == 3'd7))
    else $error("digest match flagged on a word other than the last");

  // After the final word leaves, no word follows until a new block arrives.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> !out_valid)
    else $error("digest word emitted right after the last word");

endmodule
